// ===== hdl/sibe_pkg.sv =====
package sibe_pkg;

  localparam int ID_W    = 31;
  localparam int KEY_W   = 2 * ID_W;
  localparam int ENTRY_W = 2 * KEY_W;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;
  localparam int HELD_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DRAIN  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_DRAINED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  // One result as it leaves the block.
  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   graph;
    logic [ID_W-1:0]   subject;
    logic [ID_W-1:0]   predicate;
    logic [ID_W-1:0]   object;
    logic [HELD_W-1:0] held;
    logic              last;
  } result_t;

  // Sequencer to output register.
  typedef struct packed {
    logic    push;
    result_t result;
  } push_t;

  // Stored entry layout: {subject, predicate, object, graph}; the key is the top half.
  function automatic logic [KEY_W-1:0] entry_key(input logic [ENTRY_W-1:0] e);
    entry_key = e[ENTRY_W-1 -: KEY_W];
  endfunction

endpackage

// ===== hdl/sibe_cmd_if.sv =====
interface sibe_cmd_if import sibe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   evt_graph;
  logic [ID_W-1:0]   evt_subject;
  logic [ID_W-1:0]   pred_id;
  logic [ID_W-1:0]   evt_object;

  modport source (output valid, command, evt_graph, evt_subject, pred_id, evt_object,
                  input ready);
  modport sink   (input valid, command, evt_graph, evt_subject, pred_id, evt_object,
                  output ready);
endinterface

// ===== hdl/sibe_res_if.sv =====
interface sibe_res_if import sibe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_graph;
  logic [ID_W-1:0]   out_subject;
  logic [ID_W-1:0]   out_predicate;
  logic [ID_W-1:0]   out_object;
  logic [HELD_W-1:0] entries_held;
  logic              last;

  modport source (output valid, status, out_graph, out_subject, out_predicate, out_object,
                  entries_held, last, input ready);
  modport sink   (input valid, status, out_graph, out_subject, out_predicate, out_object,
                  entries_held, last, output ready);
endinterface

// ===== hdl/sibe_ram.sv =====
module sibe_ram #(
  parameter int WIDTH = 124,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sibe_ctrl.sv =====
module sibe_ctrl import sibe_pkg::*; #(
  parameter int LIST_DEPTH = 64,
  parameter int AW         = $clog2(LIST_DEPTH),
  parameter int CW         = $clog2(LIST_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [ID_W-1:0]    evt_graph,
  input  logic [ID_W-1:0]    evt_subject,
  input  logic [ID_W-1:0]    pred_id,
  input  logic [ID_W-1:0]    evt_object,
  input  logic               slot_free,
  output push_t              push,
  output logic [CW-1:0]      count,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [ENTRY_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  logic [ENTRY_W-1:0] ram_rdata
);

  localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CMP, S_DRD, S_DOUT, S_EMIT
  } state_t;

  state_t          state;
  logic [CW-1:0]   idx;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] pay_r;
  status_t         status_r;

  logic [CW-1:0] idx_dec;
  logic [CW-1:0] idx_inc;
  logic          key_gt;
  logic          drn_last;

  assign cmd_ready = (state == S_IDLE);
  assign idx_dec   = idx - 1'b1;
  assign idx_inc   = idx + 1'b1;
  assign key_gt    = entry_key(ram_rdata) > key_r;
  assign drn_last  = (idx_inc == count);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = {key_r, pay_r};
    ram_re    = 1'b0;
    ram_raddr = idx[AW-1:0];
    push      = '0;
    unique case (state)
      S_SCAN: begin
        if (idx != '0) begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[AW-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      S_CMP: begin
        ram_we = 1'b1;
        if (key_gt) begin
          ram_wdata = ram_rdata;
        end
      end
      S_DRD: begin
        ram_re = 1'b1;
      end
      S_DOUT: begin
        push.push             = slot_free;
        push.result.status    = ST_DRAINED;
        push.result.subject   = ram_rdata[ENTRY_W-1 -: ID_W];
        push.result.predicate = ram_rdata[ENTRY_W-ID_W-1 -: ID_W];
        push.result.object    = ram_rdata[KEY_W-1 -: ID_W];
        push.result.graph     = ram_rdata[ID_W-1:0];
        push.result.held      = HELD_W'(count);
        push.result.last      = drn_last;
      end
      S_EMIT: begin
        push.push          = slot_free;
        push.result.status = status_r;
        push.result.held   = HELD_W'(count);
        push.result.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (command)
              CMD_INSERT: begin
                key_r <= {evt_subject, pred_id};
                pay_r <= {evt_object, evt_graph};
                idx   <= count;
                if (count == FULL) begin
                  status_r <= ST_DROPPED;
                  state    <= S_EMIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_DRAIN: begin
                idx <= '0;
                if (count == '0) begin
                  status_r <= ST_EMPTY;
                  state    <= S_EMIT;
                end else begin
                  state <= S_DRD;
                end
              end
              CMD_CLEAR: begin
                count    <= '0;
                status_r <= ST_CLEARED;
                state    <= S_EMIT;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (idx == '0) begin
            count    <= count + 1'b1;
            status_r <= ST_INSERTED;
            state    <= S_EMIT;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (key_gt) begin
            idx   <= idx_dec;
            state <= S_SCAN;
          end else begin
            count    <= count + 1'b1;
            status_r <= ST_INSERTED;
            state    <= S_EMIT;
          end
        end
        S_DRD: begin
          state <= S_DOUT;
        end
        S_DOUT: begin
          if (slot_free) begin
            idx   <= idx_inc;
            state <= drn_last ? S_IDLE : S_DRD;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/sorted_insert_event_buffer_unit.sv =====
// Sorted insertion event buffer.
// Requests arrive on cmd (valid/ready): insert an event, drain the list, or
// clear it. Results leave on res (valid/ready), each with a status, the ids
// of a drained entry (zero otherwise), the entry count and a last mark.
// The list lives in one RAM of LIST_DEPTH entries, kept sorted by
// {subject, predicate}; equal keys stay in arrival order.
// An insert walks down from the top of the list with one shared key
// comparator, moving up each entry that holds a larger key (RAM read,
// then compare and write), and gives a single result once the new entry
// is written. A drain emits the held entries in list order, each by a
// RAM read, then output; clear, drop and empty drain answer after one
// cycle. cmd.ready is high only while the sequencer is idle, so one
// request is in work at a time.
// A one-deep output register sits before res; the sequencer holds while it
// is full and res.ready is low, so a stalled receiver stalls the block and
// nothing is lost. Reset empties the list; RAM contents are not cleared and
// are never read above the entry count.
module sorted_insert_event_buffer_unit import sibe_pkg::*; #(
  parameter int LIST_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  sibe_cmd_if.sink   cmd,
  sibe_res_if.source res
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  push_t              push;
  logic [CW-1:0]      count;
  logic               slot_free;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic    out_valid;
  result_t out_r;

  // Sequencer with the shared key comparator.
  sibe_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .command     (cmd.command),
    .evt_graph   (cmd.evt_graph),
    .evt_subject (cmd.evt_subject),
    .pred_id     (cmd.pred_id),
    .evt_object  (cmd.evt_object),
    .slot_free   (slot_free),
    .push        (push),
    .count       (count),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // Entry store: key and payload side by side.
  sibe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Output register: free when empty or being taken this cycle.
  assign slot_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= push.push;
    end
  end

  // Hold the payload until the next push.
  always_ff @(posedge clk) begin
    if (push.push) begin
      out_r <= push.result;
    end
  end

  assign res.valid         = out_valid;
  assign res.status        = out_r.status;
  assign res.out_graph     = out_r.graph;
  assign res.out_subject   = out_r.subject;
  assign res.out_predicate = out_r.predicate;
  assign res.out_object    = out_r.object;
  assign res.entries_held  = out_r.held;
  assign res.last          = out_r.last;

  // Never push into a full output register.
  a_push_slot: assert property (@(posedge clk) disable iff (rst)
    push.push |-> slot_free)
    else $error("push while output register full");

  // No result is produced in the cycle a request is accepted.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |-> !push.push)
    else $error("result pushed on request accept");

  // Count stays in range and moves by one up or drops to zero.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count <= CW'(LIST_DEPTH)) &&
      (count == $past(count) || count == $past(count) + 1'b1 || count == '0))
    else $error("entry count out of step");

endmodule

// ===== verif/sorted_insert_event_buffer_unit_tb.sv =====
module sorted_insert_event_buffer_unit_tb;
  import sibe_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int TARGET_REQUESTS = 260;
  // Receiver hold-off used to back the block up into its request port.
  localparam int HOLD_CYCLES = 400;
  // Above the slowest stall-free insert, which moves LIST_DEPTH-1 entries.
  localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int MAX_PRINTED = 40;
  localparam int IDLE_PCT = 38;

  // Command code that the block does not decode; it must be swallowed silently.
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam logic [ID_W-1:0] MAX_ID = {ID_W{1'b1}};

  // One held event, ids in natural order; the sort key is {subject, predicate}.
  typedef struct packed {
    logic [ID_W-1:0] subject;
    logic [ID_W-1:0] predicate;
    logic [ID_W-1:0] object;
    logic [ID_W-1:0] graph;
  } list_entry_t;

  // Mirror of the sorted list plus the queue of results still owed by the block.
  class event_list_scoreboard;
    list_entry_t held_entries[$];
    result_t     awaited[$];
    int unsigned mismatches, results_seen;
    int unsigned inserted, dropped, drained, empty_drains, clears, ignored, peak_fill;

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void queue_result(status_t st, list_entry_t e, logic last_mark);
      result_t r;
      r.status    = st;
      r.graph     = e.graph;
      r.subject   = e.subject;
      r.predicate = e.predicate;
      r.object    = e.object;
      r.held      = HELD_W'(held_entries.size());
      r.last      = last_mark;
      awaited.push_back(r);
    endfunction

    // Apply one accepted request to the mirror and queue what it must produce.
    function void note_request(logic [CMD_W-1:0] code, list_entry_t ev);
      list_entry_t blank;
      int pos;
      blank = '0;
      case (code)
        CMD_INSERT: begin
          if (held_entries.size() >= LIST_DEPTH) begin
            dropped++;
            queue_result(ST_DROPPED, blank, 1'b1);
          end else begin
            // land after every entry with a key less than or equal to ours
            pos = 0;
            while (pos < held_entries.size() &&
                   {held_entries[pos].subject, held_entries[pos].predicate} <=
                   {ev.subject, ev.predicate})
              pos++;
            held_entries.insert(pos, ev);
            inserted++;
            if (held_entries.size() > peak_fill) peak_fill = held_entries.size();
            queue_result(ST_INSERTED, blank, 1'b1);
          end
        end
        CMD_DRAIN: begin
          if (held_entries.size() == 0) begin
            empty_drains++;
            queue_result(ST_EMPTY, blank, 1'b1);
          end else begin
            for (int i = 0; i < held_entries.size(); i++)
              queue_result(ST_DRAINED, held_entries[i], i == held_entries.size() - 1);
            drained += held_entries.size();
          end
        end
        CMD_CLEAR: begin
          held_entries.delete();
          clears++;
          queue_result(ST_CLEARED, blank, 1'b1);
        end
        default: ignored++;
      endcase
    endfunction

    task report(string what);
      if (mismatches < MAX_PRINTED) $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited: status %0d held %0d last %0b",
                         got.status, got.held, got.last));
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status || got.graph !== want.graph ||
            got.subject !== want.subject || got.predicate !== want.predicate ||
            got.object !== want.object || got.held !== want.held ||
            got.last !== want.last)
          report($sformatf({"result %0d: got st %0d g %h s %h p %h o %h held %0d last %0b,",
                            " want st %0d g %h s %h p %h o %h held %0d last %0b"},
                           results_seen, got.status, got.graph, got.subject,
                           got.predicate, got.object, got.held, got.last,
                           want.status, want.graph, want.subject, want.predicate,
                           want.object, want.held, want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  sibe_cmd_if cmd_if ();
  sibe_res_if res_if ();

  sorted_insert_event_buffer_unit #(.LIST_DEPTH(LIST_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  event_list_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int hold_seq = 0;   // bump to make the receiver start one long hold-off
  bit gaps_on = 1'b1; // random idling on both sides; off for one stretch

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still awaited", cycle_count, sb.pending());
    $display("sorted_insert_event_buffer_unit_tb failed");
    $finish;
  end

  function automatic list_entry_t make_event(logic [ID_W-1:0] s, logic [ID_W-1:0] p,
                                             logic [ID_W-1:0] o, logic [ID_W-1:0] g);
    list_entry_t e;
    e.subject   = s;
    e.predicate = p;
    e.object    = o;
    e.graph     = g;
    return e;
  endfunction

  // Key ids lean toward a few values so equal keys and ties show up often,
  // while the plain random share still toggles every bit.
  function automatic logic [ID_W-1:0] random_key_id();
    case ($urandom_range(5))
      0:       return '0;
      1:       return MAX_ID;
      2:       return ID_W'($urandom_range(3));
      3:       return MAX_ID - ID_W'($urandom_range(3));
      default: return ID_W'($urandom);
    endcase
  endfunction

  function automatic list_entry_t random_event();
    return make_event(random_key_id(), random_key_id(), ID_W'($urandom), ID_W'($urandom));
  endfunction

  // Offer one request and hold it until the block takes it. Valid stays high
  // on return so back-to-back requests never drop it for a cycle.
  task automatic send_request(logic [CMD_W-1:0] code, list_entry_t ev);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= code;
    cmd_if.evt_subject <= ev.subject;
    cmd_if.pred_id     <= ev.predicate;
    cmd_if.evt_object  <= ev.object;
    cmd_if.evt_graph   <= ev.graph;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sb.note_request(code, ev);
    if (code != CMD_IGNORED) requests_sent++;
  endtask

  // Receiver: check each accepted result, then pick ready for the next edge.
  // A hold-off request loads a counter from HOLD_CYCLES that keeps ready low until it runs out.
  initial begin : receiver
    int hold_count;
    int hold_seen;
    result_t got;
    hold_count = 0;
    hold_seen  = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got.status    = status_t'(res_if.status);
        got.graph     = res_if.out_graph;
        got.subject   = res_if.out_subject;
        got.predicate = res_if.out_predicate;
        got.object    = res_if.out_object;
        got.held      = res_if.entries_held;
        got.last      = res_if.last;
        sb.check_result(got);
      end
      if (hold_seq != hold_seen) begin
        hold_seen  = hold_seq;
        hold_count = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
        hold_count--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    list_entry_t none;
    int burst;
    int pick;
    none = '0;

    // Hold every input at a known value through reset.
    rst                 <= 1'b1;
    cmd_if.valid        <= 1'b0;
    cmd_if.command      <= CMD_INSERT;
    cmd_if.evt_subject  <= '0;
    cmd_if.pred_id      <= '0;
    cmd_if.evt_object   <= '0;
    cmd_if.evt_graph    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list first, then extremes and ordering corner cases.
    send_request(CMD_DRAIN, none);
    send_request(CMD_CLEAR, none);
    send_request(CMD_INSERT, make_event(MAX_ID, MAX_ID, MAX_ID, MAX_ID));
    send_request(CMD_INSERT, make_event('0, '0, '0, '0));
    send_request(CMD_INSERT, make_event(31'd5, MAX_ID, 31'd1, 31'd2));
    // subject outranks predicate: this one sorts after the one above
    send_request(CMD_INSERT, make_event(31'd6, '0, 31'd3, 31'd4));
    // equal keys must stay in arrival order
    send_request(CMD_INSERT, make_event(31'd5, MAX_ID, 31'd7, 31'd8));
    send_request(CMD_INSERT, make_event(31'd5, MAX_ID, 31'd9, 31'd10));
    send_request(CMD_INSERT, make_event('0, '0, MAX_ID, 31'd11));
    send_request(CMD_IGNORED, random_event());
    send_request(CMD_DRAIN, none);
    // drain keeps the list, so a second drain repeats it
    send_request(CMD_DRAIN, none);
    send_request(CMD_CLEAR, none);
    send_request(CMD_DRAIN, none);
    send_request(CMD_INSERT, make_event(31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA, 31'h55555555));
    send_request(CMD_INSERT, make_event(31'h55555555, 31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA));
    send_request(CMD_DRAIN, none);
    send_request(CMD_CLEAR, none);

    // Fill to capacity while the receiver holds off, so results back up and
    // the block stalls its request port; then drain a full list and overflow.
    send_request(CMD_CLEAR, none);
    hold_seq <= hold_seq + 1;
    repeat (LIST_DEPTH + 2)
      send_request(CMD_INSERT, make_event(ID_W'($urandom_range(3)), ID_W'($urandom_range(3)),
                                          ID_W'($urandom), ID_W'($urandom)));
    send_request(CMD_DRAIN, none);
    repeat (3) send_request(CMD_INSERT, random_event());
    send_request(CMD_IGNORED, random_event());
    send_request(CMD_DRAIN, none);
    send_request(CMD_CLEAR, none);

    // Random: mostly insert bursts closed by a drain, with stray clears,
    // lone drains and undecoded commands mixed in.
    while (requests_sent < TARGET_REQUESTS) begin
      gaps_on <= !(requests_sent >= 150 && requests_sent < 200);
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_request(CMD_IGNORED, random_event());
      end else if (pick < 14) begin
        send_request(CMD_CLEAR, none);
      end else if (pick < 22) begin
        send_request(CMD_DRAIN, none);
      end else begin
        burst = $urandom_range(1, 12);
        repeat (burst) send_request(CMD_INSERT, random_event());
        send_request(CMD_DRAIN, none);
      end
    end

    // Drain everything still owed, then watch for stray results.
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d inserts, %0d dropped when full, %0d clears, %0d ignored",
             requests_sent, sb.inserted, sb.dropped, sb.clears, sb.ignored);
    $display("drained %0d entries and %0d empty lists, peak fill %0d of %0d, %0d results checked",
             sb.drained, sb.empty_drains, sb.peak_fill, LIST_DEPTH, sb.results_seen);
    if (sb.mismatches == 0) begin
      $display("sorted_insert_event_buffer_unit_tb passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("sorted_insert_event_buffer_unit_tb failed");
    end
    $finish;
  end

endmodule
